// ----- hdl/etl_pkg.sv -----
`default_nettype none

package etl_pkg;

    // fixed field widths
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 31;
    localparam int HANDLE_W = 32;
    localparam int KIND_W   = 2;

    // request codes
    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // result codes
    localparam logic [KIND_W-1:0] KIND_ADDED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    // shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              expired;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/etl_alu.sv -----
`default_nettype none

module etl_alu (
    input  var etl_pkg::alu_req_t req,
    output var etl_pkg::alu_rsp_t rsp
);
    import etl_pkg::*;

    logic [TIME_W-1:0] result;

    // one adder serves both expiry computation and the wrap-safe compare
    always_comb
    begin
        case (req.op)
            ALU_ADD: result = req.a + req.b;
            ALU_SUB: result = req.a - req.b;
            default: result = req.a + req.b;
        endcase
    end

    // signed difference at most zero: zero or negative
    assign rsp.sum     = result;
    assign rsp.expired = (result == '0) || result[TIME_W-1];

endmodule

`default_nettype wire

// ----- hdl/etl_slot_mem.sv -----
`default_nettype none

module etl_slot_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  var logic                             clk,
    input  var logic                             wr_en,
    input  var logic [IDX_W-1:0]                 wr_addr,
    input  var logic [etl_pkg::TIME_W-1:0]       wr_expiry,
    input  var logic [etl_pkg::HANDLE_W-1:0]     wr_handle,
    input  var logic                             rd_en,
    input  var logic [IDX_W-1:0]                 rd_addr,
    output var logic [etl_pkg::TIME_W-1:0]       rd_expiry,
    output var logic [etl_pkg::HANDLE_W-1:0]     rd_handle
);
    import etl_pkg::*;

    logic [TIME_W-1:0]   expiry_mem [DEPTH];
    logic [HANDLE_W-1:0] handle_mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            expiry_mem[wr_addr] <= wr_expiry;
            handle_mem[wr_addr] <= wr_handle;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_expiry <= expiry_mem[rd_addr];
            rd_handle <= handle_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/expiring_timer_table.sv -----
`default_nettype none

// channel   direction  handshake           word
// input     in         in_valid, in_stall  func, delay_ms, handle, now_ms
// result    out        out_valid, out_stall kind, fired_handle, last
//
// add: scans up from slot 0 past occupied slots to the lowest free one, else reports full
// dispatch: one slot a cycle through the single comparator, held while a hit waits on the output
// a dispatch gives one word per fired slot, or one none word if nothing fired; each waits while out_stall is high
// reset clears all slot valid bits at once, no clearing pass; stored words need none
// in_stall stays high from acceptance until the final word is in the output register

module expiring_timer_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  var logic                             clk,
    input  var logic                             rst_n,
    input  var logic                             in_valid,
    output var logic                             in_stall,
    input  var logic                             func,
    input  var logic [etl_pkg::DELAY_W-1:0]      delay_ms,
    input  var logic [etl_pkg::HANDLE_W-1:0]     handle,
    input  var logic [etl_pkg::TIME_W-1:0]       now_ms,
    output var logic                             out_valid,
    input  var logic                             out_stall,
    output var logic [etl_pkg::KIND_W-1:0]       kind,
    output var logic [etl_pkg::HANDLE_W-1:0]     fired_handle,
    output var logic                             last
);
    import etl_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_DSP_CMP,
        ST_DSP_END,
        ST_RESULT
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [DELAY_W-1:0]       delay_reg, delay_next;
    logic [HANDLE_W-1:0]      handle_reg, handle_next;
    logic [TIME_W-1:0]        now_reg, now_next;
    logic [TIMER_SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0]      pend_handle_reg, pend_handle_next;
    logic [KIND_W-1:0]        res_kind_reg, res_kind_next;
    logic                     out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [HANDLE_W-1:0]      fired_handle_reg, fired_handle_next;
    logic                     last_reg, last_next;

    logic                     mem_wr_en;
    logic                     mem_rd_en;
    logic [IDX_W-1:0]         mem_rd_addr;
    logic [TIME_W-1:0]        rd_expiry;
    logic [HANDLE_W-1:0]      rd_handle;
    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;
    logic                     out_free;
    logic                     hit;
    logic                     advance;

    // shared adder and comparator
    etl_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // expiry and handle store
    etl_slot_mem #(
        .DEPTH (TIMER_SLOTS),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (idx_reg),
        .wr_expiry (alu_rsp.sum),
        .wr_handle (handle_reg),
        .rd_en     (mem_rd_en),
        .rd_addr   (mem_rd_addr),
        .rd_expiry (rd_expiry),
        .rd_handle (rd_handle)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign hit      = slot_valid_reg[idx_reg] && alu_rsp.expired;
    assign advance  = !hit || !pend_valid_reg || out_free;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        delay_next        = delay_reg;
        handle_next       = handle_reg;
        now_next          = now_reg;
        slot_valid_next   = slot_valid_reg;
        pend_valid_next   = pend_valid_reg;
        pend_handle_next  = pend_handle_reg;
        res_kind_next     = res_kind_reg;
        out_valid_next    = out_valid_reg;
        kind_next         = kind_reg;
        fired_handle_next = fired_handle_reg;
        last_next         = last_reg;
        mem_wr_en         = 1'b0;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = idx_reg;
        alu_req.op        = ALU_ADD;
        alu_req.a         = now_reg;
        alu_req.b         = {1'b0, delay_reg};

        // output word taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next    = now_ms;
                    delay_next  = delay_ms;
                    handle_next = handle;
                    idx_next    = '0;
                    if (func == FUNC_ADD)
                    begin
                        state_next = ST_ADD_SCAN;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        mem_rd_en       = 1'b1;
                        mem_rd_addr     = '0;
                        state_next      = ST_DSP_CMP;
                    end
                end
            end

            // look for the lowest free slot, one a cycle
            ST_ADD_SCAN:
            begin
                if (!slot_valid_reg[idx_reg])
                begin
                    mem_wr_en                = 1'b1;
                    slot_valid_next[idx_reg] = 1'b1;
                    res_kind_next            = KIND_ADDED;
                    state_next               = ST_RESULT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_kind_next = KIND_FULL;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // compare one slot a cycle unless a hit waits on a busy output, hold back the latest hit to mark last
            ST_DSP_CMP:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = rd_expiry;
                alu_req.b  = now_reg;
                if (hit && pend_valid_reg && out_free)
                begin
                    out_valid_next    = 1'b1;
                    kind_next         = KIND_FIRED;
                    fired_handle_next = pend_handle_reg;
                    last_next         = 1'b0;
                end
                if (hit && advance)
                begin
                    pend_valid_next          = 1'b1;
                    pend_handle_next         = rd_handle;
                    slot_valid_next[idx_reg] = 1'b0;
                end
                if (advance)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DSP_END;
                    end
                    else
                    begin
                        idx_next    = idx_reg + IDX_W'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg + IDX_W'(1);
                    end
                end
            end

            // final word of a dispatch
            ST_DSP_END:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    last_next         = 1'b1;
                    kind_next         = pend_valid_reg ? KIND_FIRED : KIND_NONE;
                    fired_handle_next = pend_valid_reg ? pend_handle_reg : '0;
                    pend_valid_next   = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            // single word of an add
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    last_next         = 1'b1;
                    kind_next         = res_kind_reg;
                    fired_handle_next = '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            delay_reg        <= '0;
            handle_reg       <= '0;
            now_reg          <= '0;
            slot_valid_reg   <= '0;
            pend_valid_reg   <= 1'b0;
            pend_handle_reg  <= '0;
            res_kind_reg     <= KIND_ADDED;
            out_valid_reg    <= 1'b0;
            kind_reg         <= KIND_ADDED;
            fired_handle_reg <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            delay_reg        <= delay_next;
            handle_reg       <= handle_next;
            now_reg          <= now_next;
            slot_valid_reg   <= slot_valid_next;
            pend_valid_reg   <= pend_valid_next;
            pend_handle_reg  <= pend_handle_next;
            res_kind_reg     <= res_kind_next;
            out_valid_reg    <= out_valid_next;
            kind_reg         <= kind_next;
            fired_handle_reg <= fired_handle_next;
            last_reg         <= last_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign fired_handle = fired_handle_reg;
    assign last         = last_reg;

    // checks
    a_single_word_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ADDED || kind == KIND_FULL || kind == KIND_NONE)
        |-> last)
        else $error("add or none word without last");

    a_no_handle_unless_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_FIRED |-> fired_handle == '0)
        else $error("handle on a word that fired nothing");

    a_pending_in_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_DSP_CMP || state_reg == ST_DSP_END))
        else $error("held fired word outside a dispatch");

    a_add_sets_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |=> $countones(slot_valid_reg) == $countones($past(slot_valid_reg)) + 1)
        else $error("add did not occupy exactly one new slot");

endmodule

`default_nettype wire
